// File: rtl/core/case_blind_substring_match_assert.svh
// Assertion macros for the case-blind substring matcher.
`ifndef CASE_BLIND_SUBSTRING_MATCH_ASSERT_SVH
`define CASE_BLIND_SUBSTRING_MATCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/csm_pkg.sv
// Shared constants, types and the character compare function for the case-blind substring matcher.
`default_nettype none

package csm_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int CHAR_W          = 8;
  localparam int LEN_W           = 4;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CHAR_W-1:0] FOLD_MASK = 8'hdf;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic step;    // request carries a character
    logic clear;   // final request of the haystack
    logic pat_we;  // pattern bytes being written
  } cell_ctrl_t;

  // Equal after folding bit 5
  function automatic logic chars_equal(input logic [CHAR_W-1:0] a,
                                       input logic [CHAR_W-1:0] b);
    chars_equal = ((a ^ b) & FOLD_MASK) == '0;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/csm_cell.sv
// One pattern position: holds its pattern byte and its prefix-hit bit.
`default_nettype none

module csm_cell #(
  parameter bit FIRST = 1'b0
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire csm_pkg::cell_ctrl_t      ctrl,
  input  wire [csm_pkg::CHAR_W-1:0]     pat_byte,
  input  wire [csm_pkg::CHAR_W-1:0]     ch,
  input  wire                           enable,   // position lies inside the pattern
  input  wire                           prev_hit, // neighbor's stored hit
  output logic                          hit_r,
  output logic                          hit_now   // hit including current character
);

  logic [csm_pkg::CHAR_W-1:0] pat_byte_r;

  assign hit_now = (prev_hit | FIRST) & enable & csm_pkg::chars_equal(pat_byte_r, ch);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_byte_r <= '0;
      hit_r      <= 1'b0;
    end else begin
      if (ctrl.pat_we) begin
        pat_byte_r <= pat_byte;
      end
      if (ctrl.clear) begin
        hit_r <= 1'b0;
      end else if (ctrl.step) begin
        hit_r <= hit_now;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/case_blind_substring_match.sv
// Top level of the case-blind substring matcher: cell chain, match flags, result skid.
// Throughput: one request per cycle while the skid is empty; a skid stage keeps intake going
//   while one result waits on a stalled output.
// Latency: a final request's result is valid the cycle after acceptance unless the output is stalled.
// Per-character update is one pass through a cell: a folded byte compare and an AND.
// Reset (rst_n low at a clock edge) clears pattern, length, hit chain, flags, results.
`default_nettype none

module case_blind_substring_match #(
  parameter int PATTERN_MAX = csm_pkg::PATTERN_MAX_DEF  // 1..8 pattern characters
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // haystack requests
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire [csm_pkg::CHAR_W-1:0]        in_ch,
  input  wire                              in_no_char,
  input  wire                              in_last,
  // results
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_found,
  // configuration writes
  input  wire                              cfg_we,
  input  wire [csm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [csm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  `include "case_blind_substring_match_assert.svh"

  localparam int LEN_W = csm_pkg::LEN_W;

  // ---------------------------------------------------------------------------
  // Configuration: pattern bytes live inside the cells, the length lives here.
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] pat_len_r;
  logic [LEN_W-1:0] len_eff;
  logic             pat_bytes_we;
  logic             pat_len_we;

  always_comb begin
    pat_bytes_we = 1'b0;
    pat_len_we   = 1'b0;
    unique case (cfg_index)
      csm_pkg::REG_PATTERN_BYTES:  pat_bytes_we = cfg_we;
      csm_pkg::REG_PATTERN_LENGTH: pat_len_we   = cfg_we;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= '0;
    end else if (pat_len_we) begin
      pat_len_r <= cfg_wdata[LEN_W-1:0];
    end
  end

  // Lengths past the chain behave as a full-length pattern
  assign len_eff = (pat_len_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_r;

  // ---------------------------------------------------------------------------
  // Request handshake and cell control
  // ---------------------------------------------------------------------------
  logic                 in_acc;
  csm_pkg::cell_ctrl_t  ctrl;

  assign in_acc     = in_valid & ~in_stall;
  assign ctrl.step  = in_acc & ~in_no_char;
  assign ctrl.clear = in_acc & in_last;
  assign ctrl.pat_we = pat_bytes_we;

  // ---------------------------------------------------------------------------
  // Shift-and chain: cell k holds "pattern[0..k] ends at the latest character"
  // and hands that bit to cell k+1 for the next character.
  // ---------------------------------------------------------------------------
  logic [PATTERN_MAX-1:0] hit_r;
  logic [PATTERN_MAX-1:0] hit_now;
  logic [PATTERN_MAX-1:0] end_hit;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_head
      assign prev = 1'b0;
    end else begin : g_link
      assign prev = hit_r[k-1];
    end

    csm_cell #(
      .FIRST (k == 0)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .pat_byte (cfg_wdata[k*csm_pkg::CHAR_W +: csm_pkg::CHAR_W]),
      .ch       (in_ch),
      .enable   (LEN_W'(k) < len_eff),
      .prev_hit (prev),
      .hit_r    (hit_r[k]),
      .hit_now  (hit_now[k])
    );

    // full match only counts at the cell of the last pattern character
    assign end_hit[k] = hit_now[k] & (len_eff == LEN_W'(k + 1));
  end

  // ---------------------------------------------------------------------------
  // Per-haystack flags
  // ---------------------------------------------------------------------------
  logic seen_match_r, seen_match_nxt;
  logic seen_char_r, seen_char_nxt;
  logic res_found;

  assign seen_match_nxt = seen_match_r | (ctrl.step & (|end_hit));
  assign seen_char_nxt  = seen_char_r | ctrl.step;
  // empty pattern matches any haystack that held a character
  assign res_found      = seen_char_nxt & ((len_eff == '0) | seen_match_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_match_r <= 1'b0;
      seen_char_r  <= 1'b0;
    end else if (ctrl.clear) begin
      seen_match_r <= 1'b0;
      seen_char_r  <= 1'b0;
    end else begin
      seen_match_r <= seen_match_nxt;
      seen_char_r  <= seen_char_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register plus skid: a new result lands in the skid while the output
  // is held; intake stops only once the skid is occupied.
  // ---------------------------------------------------------------------------
  logic out_valid_r, out_found_r;
  logic skid_valid_r, skid_found_r;
  logic out_free;

  assign out_free = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_found_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      skid_found_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_found_r  <= skid_found_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= ctrl.clear;
        out_found_r <= res_found;
      end
    end else if (ctrl.clear) begin
      skid_valid_r <= 1'b1;
      skid_found_r <= res_found;
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CSM_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r,
                   "skid holds a result while output register is empty")
  `CSM_ASSERT_NEXT(a_skid_fill_cause, clk, rst_n, !skid_valid_r && !(out_valid_r && out_stall),
                   !skid_valid_r, "skid filled although output was free")
  `CSM_ASSERT_NEXT(a_nonlast_no_result, clk, rst_n,
                   in_acc && !in_last && !out_valid_r && !skid_valid_r, !out_valid_r,
                   "result produced by a non-final request")
  `CSM_ASSERT_NEXT(a_clear_after_last, clk, rst_n, ctrl.clear,
                   !seen_char_r && !seen_match_r && (hit_r == '0),
                   "state not cleared after final request")

endmodule

`default_nettype wire

// File: verif/case_blind_substring_match_tb.sv
// Self-checking testbench for the case-blind substring matcher.
`timescale 1ns / 100ps

module case_blind_substring_match_tb;

  // Fold used by the predictor: bit 5 ignored in every compare
  localparam logic [7:0] CASE_FOLD = 8'hdf;
  localparam int RANDOM_REQUESTS = 1350;

  // ---------------------------------------------------------------------
  // Scoreboard: shadows the pattern registers and the shift-and state,
  // queues the found bit predicted for every final request, and checks
  // each accepted result against the oldest prediction.
  // ---------------------------------------------------------------------
  class search_board;
    logic [63:0] pat_bytes;
    logic [3:0]  pat_len;
    logic [7:0]  prefix_vec;
    bit          full_seen;
    bit          char_seen;
    bit          found_q[$];
    int          errors;

    function new();
      pat_bytes  = '0;
      pat_len    = '0;
      prefix_vec = '0;
      full_seen  = 1'b0;
      char_seen  = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic [csm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
      if (idx == csm_pkg::REG_PATTERN_BYTES) begin
        pat_bytes = data;
      end else if (idx == csm_pkg::REG_PATTERN_LENGTH) begin
        pat_len = data[3:0];
      end
    endfunction

    function void note_request(logic [7:0] ch, bit no_char, bit last);
      int n;
      logic [7:0] eq;
      n  = (pat_len > 4'd8) ? 8 : int'(pat_len);
      eq = '0;
      for (int k = 0; k < n; k++) begin
        if (((pat_bytes[8*k +: 8] ^ ch) & CASE_FOLD) == 8'h00) eq[k] = 1'b1;
      end
      if (!no_char) begin
        prefix_vec = ((prefix_vec << 1) | 8'h01) & eq;
        if (n > 0 && prefix_vec[n-1]) full_seen = 1'b1;
        char_seen = 1'b1;
      end
      if (last) begin
        found_q.push_back(char_seen && (n == 0 || full_seen));
        prefix_vec = '0;
        full_seen  = 1'b0;
        char_seen  = 1'b0;
      end
    endfunction

    function void check_found(logic actual);
      bit want;
      if (found_q.size() == 0) begin
        $error("found: unexpected result, expected none, actual %0d", actual);
        errors++;
      end else begin
        want = found_q.pop_front();
        if (actual !== want) begin
          $error("found: expected %0d, actual %0d", want, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return found_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // DUT signals; the bench drives its inputs to known values from time zero
  // ---------------------------------------------------------------------
  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_valid   = 1'b0;
  logic                           in_stall;
  logic [csm_pkg::CHAR_W-1:0]     in_ch      = '0;
  logic                           in_no_char = 1'b0;
  logic                           in_last    = 1'b0;
  logic                           out_valid;
  logic                           out_stall  = 1'b0;
  logic                           out_found;
  logic                           cfg_we     = 1'b0;
  logic [csm_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [csm_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  search_board board = new();

  bit in_burst  = 1'b0;  // sender inserts no gaps while set
  bit out_burst = 1'b0;  // receiver draws no new stalls while set
  int stall_left = 0;
  int requests_sent = 0;  // requests that carry a char or end a haystack

  case_blind_substring_match uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_ch      (in_ch),
    .in_no_char (in_no_char),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_found  (out_found),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Result side: check each accepted result, then draw how long to hold
  // off the next one. The stall runs whether or not a result is waiting,
  // so it lands on every phase of the block's work.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_found(out_found);
      stall_left = out_burst ? 0 : $urandom_range(0, 10);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // One request: optional gap, then hold it until the block takes it.
  // valid stays high after acceptance so back-to-back requests need
  // only one assignment per edge.
  task automatic send_request(input logic [7:0] ch, input bit no_char, input bit last);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_ch      <= ch;
    in_no_char <= no_char;
    in_last    <= last;
    do @(posedge clk); while (in_stall);
    board.note_request(ch, no_char, last);
    if (!no_char || last) requests_sent++;
  endtask

  // Stop sending, wait for every predicted result, then let the block
  // settle any request that produced no result.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both registers back to back; upper bits of the length word are junk
  // on purpose since only the low nibble is kept.
  task automatic load_pattern(input logic [63:0] bytes, input logic [3:0] len);
    logic [63:0] len_word;
    len_word = {$urandom, 28'($urandom_range(0, 32'h0fff_ffff)), len};
    cfg_we    <= 1'b1;
    cfg_index <= csm_pkg::REG_PATTERN_BYTES;
    cfg_wdata <= bytes;
    @(posedge clk);
    board.set_reg(csm_pkg::REG_PATTERN_BYTES, bytes);
    cfg_index <= csm_pkg::REG_PATTERN_LENGTH;
    cfg_wdata <= len_word;
    @(posedge clk);
    board.set_reg(csm_pkg::REG_PATTERN_LENGTH, len_word);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] flip_case(input logic [7:0] b);
    return ($urandom_range(0, 3) == 0) ? (b ^ 8'h20) : b;
  endfunction

  // Haystack char: often a pattern char so partial prefixes build up
  function automatic logic [7:0] pick_char(input logic [63:0] pat, input int n);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && n > 0) return flip_case(pat[8*$urandom_range(0, n-1) +: 8]);
    if (r < 7) return 8'($urandom);
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'h20;
      2: return 8'h41;
      default: return 8'h61;
    endcase
  endfunction

  // One haystack: random text, usually with a full or cut-short copy of
  // the pattern spliced in; some end on a char-less final request, some
  // are empty, and a few ignored char-less requests fall in between.
  task automatic send_haystack(input logic [63:0] pat, input int n);
    logic [7:0] text[$];
    int mode, len_text, pos, cnt;
    bit tail_empty;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(0, 2)) send_request(8'($urandom), 1'b1, 1'b0);
      send_request(8'($urandom), 1'b1, 1'b1);
      return;
    end
    len_text = $urandom_range(1, 12);
    for (int k = 0; k < len_text; k++) text.push_back(pick_char(pat, n));
    if (n > 0 && mode <= 6) begin
      cnt = (mode <= 2) ? $urandom_range(1, n) : n;
      pos = $urandom_range(0, len_text);
      for (int k = 0; k < cnt; k++) text.insert(pos + k, flip_case(pat[8*k +: 8]));
    end
    tail_empty = ($urandom_range(0, 7) == 0);
    for (int k = 0; k < text.size(); k++) begin
      if ($urandom_range(0, 19) == 0) send_request(8'($urandom), 1'b1, 1'b0);
      send_request(text[k], 1'b0, !tail_empty && (k == text.size() - 1));
    end
    if (tail_empty) send_request(8'($urandom), 1'b1, 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int phase;
    int plen;
    int eff;
    logic [63:0] pbytes;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset config: empty pattern matches any haystack with a char,
    // while an empty haystack never matches.
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'h5a, 1'b1, 1'b0);  // ignored, no char and not final
    send_request(8'h00, 1'b1, 1'b1);
    drain();

    // "Ab" against "xaB", closed by a char-less final request
    load_pattern(64'h6241, 4'd2);
    send_request(8'h78, 1'b0, 1'b0);
    send_request(8'h61, 1'b0, 1'b0);
    send_request(8'h42, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b1);
    drain();

    // Zero pattern byte is a real char and folds onto a space;
    // a zero haystack char is compared the same way.
    load_pattern(64'hff00, 4'd2);
    send_request(8'h20, 1'b0, 1'b0);
    send_request(8'hdf, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    drain();

    // All-ones pattern with a length past the maximum: clamps to eight
    load_pattern(64'hffff_ffff_ffff_ffff, 4'hf);
    for (int k = 0; k < 8; k++) send_request((k % 2) ? 8'hdf : 8'hff, 1'b0, k == 7);
    drain();

    // Pattern swapped mid-haystack: the prefix bit from 'a' survives
    // and 'B' completes the new pattern "xb".
    load_pattern(64'h6261, 4'd2);
    send_request(8'h61, 1'b0, 1'b0);
    drain();
    load_pattern(64'h6278, 4'd2);
    send_request(8'h42, 1'b0, 1'b1);

    // Random phases: new pattern each phase, then a batch of haystacks.
    // Every phase starts with the sender paused until all results are in.
    requests_sent = 0;
    phase = 0;
    while (requests_sent < RANDOM_REQUESTS) begin
      drain();
      case (phase % 8)
        0: plen = 0;
        1: plen = 8;
        2: plen = $urandom_range(9, 15);
        default: plen = $urandom_range(1, 8);
      endcase
      if (phase % 13 == 5) begin
        pbytes = {$urandom, $urandom};
      end else begin
        for (int k = 0; k < 8; k++) pbytes[8*k +: 8] = flip_case(8'($urandom_range(8'h61, 8'h7a)));
      end
      load_pattern(pbytes, 4'(plen));
      eff = (plen > 8) ? 8 : plen;
      in_burst  = ($urandom_range(0, 4) == 0);
      out_burst = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(4, 12)) send_haystack(pbytes, eff);
      phase++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/csm_pkg.sv
rtl/core/csm_cell.sv
rtl/core/case_blind_substring_match.sv
verif/case_blind_substring_match_tb.sv
